>>> hw/rtl/npcs_pkg.sv
// Shared constants, types and codes for the nearest palette colour search.
// Used by npcs_front, npcs_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package npcs_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int IDX_CMP_W       = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;

    localparam int COMP_W   = 8;
    localparam int WEIGHT_W = 16;
    localparam int SQ_W     = 2 * COMP_W;
    localparam int TERM_W   = SQ_W + WEIGHT_W;
    localparam int DIST_W   = TERM_W + 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = WEIGHT_W;

    localparam logic [WEIGHT_W-1:0] RED_WEIGHT_RST   = 16'd29929;
    localparam logic [WEIGHT_W-1:0] GREEN_WEIGHT_RST = 16'd58564;
    localparam logic [WEIGHT_W-1:0] BLUE_WEIGHT_RST  = 16'd11449;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PALETTE_PRESENT,
        CFG_RED_WEIGHT,
        CFG_GREEN_WEIGHT,
        CFG_BLUE_WEIGHT
    } cfg_reg_t;

    typedef enum logic {
        OP_WRITE,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  addr;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } work_item_t;

    typedef struct packed {
        logic                palette_present;
        logic [WEIGHT_W-1:0] red_weight;
        logic [WEIGHT_W-1:0] green_weight;
        logic [WEIGHT_W-1:0] blue_weight;
    } cfg_t;

endpackage

>>> hw/rtl/npcs_front.sv
// Front end: accepts input words, classifies them as palette writes or queries
// and holds them in a short queue for the back end. Depends on npcs_pkg.
`timescale 1ns / 1ps

module npcs_front
    import npcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [7:0]        entry_index,
    input  logic [COMP_W-1:0] red,
    input  logic [COMP_W-1:0] green,
    input  logic [COMP_W-1:0] blue,
    output logic              q_valid,
    input  logic              q_pop,
    output work_item_t        q_item
);

    work_item_t        q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              in_range;
    logic              push;
    logic              push_q;
    work_item_t        new_item;

    assign in_stall = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign in_range = IDX_CMP_W'(entry_index) < IDX_CMP_W'(PALETTE_ENTRIES);
    // drop writes aimed beyond the palette here
    assign push_q   = push && (func || in_range);

    always_comb
    begin
        new_item.op    = func ? OP_QUERY : OP_WRITE;
        new_item.addr  = IDX_W'(entry_index);
        new_item.red   = red;
        new_item.green = green;
        new_item.blue  = blue;
    end

    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_q)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push_q, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_q)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

>>> hw/rtl/npcs_back.sv
// Back end: palette memory, pipelined distance scan and the output register.
// Takes queued words from npcs_front; depends on npcs_pkg.
`timescale 1ns / 1ps

module npcs_back
    import npcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_valid,
    output logic              q_pop,
    input  work_item_t        q_item,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              found,
    output logic [7:0]        best_index,
    output logic [DIST_W-1:0] best_distance,
    output logic              exact_match
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                   input logic [COMP_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic [3*COMP_W-1:0] pal_mem [PALETTE_ENTRIES];

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic                issue;
    logic                mem_we;

    logic [COMP_W-1:0]   qr_reg, qg_reg, qb_reg;

    // pipeline: read -> square -> weight -> sum -> compare
    logic [3*COMP_W-1:0] rd_data_reg;
    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0]    idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [SQ_W-1:0]     sq_r_reg, sq_g_reg, sq_b_reg;
    logic [TERM_W-1:0]   t_r_reg, t_g_reg, t_b_reg;
    logic [DIST_W-1:0]   dist_reg;

    logic [COMP_W-1:0]   dr, dg, db;
    logic                have_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [DIST_W-1:0]   best_dist_reg;
    logic                take_best;
    logic                pipe_busy;
    logic                out_free;

    logic                out_valid_reg;
    logic                found_out_reg;
    logic [7:0]          best_index_reg;
    logic [DIST_W-1:0]   best_distance_reg;
    logic                exact_match_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign mem_we    = q_pop && (q_item.op == OP_WRITE);
    assign issue     = (state_reg == S_SCAN);
    assign take_best = v4_reg && (!have_reg || (dist_reg < best_dist_reg));

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                addr_next = '0;
                if (q_pop && (q_item.op == OP_QUERY))
                begin
                    state_next = cfg.palette_present ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == IDX_W'(PALETTE_ENTRIES - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state, scan bookkeeping and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            addr_reg      <= '0;
            have_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            if (q_pop && (q_item.op == OP_QUERY))
            begin
                have_reg  <= 1'b0;
                found_reg <= cfg.palette_present;
            end
            else if (take_best)
            begin
                have_reg <= 1'b1;
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && (q_item.op == OP_QUERY))
        begin
            qr_reg        <= q_item.red;
            qg_reg        <= q_item.green;
            qb_reg        <= q_item.blue;
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
        end
        else if (take_best)
        begin
            best_idx_reg  <= idx4_reg;
            best_dist_reg <= dist_reg;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            found_out_reg     <= found_reg;
            best_index_reg    <= 8'(best_idx_reg);
            best_distance_reg <= best_dist_reg;
            exact_match_reg   <= found_reg && (best_dist_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pal_mem[q_item.addr] <= {q_item.red, q_item.green, q_item.blue};
        end
        rd_data_reg <= pal_mem[addr_reg];
    end

    assign dr = abs_diff(qr_reg, rd_data_reg[3*COMP_W-1:2*COMP_W]);
    assign dg = abs_diff(qg_reg, rd_data_reg[2*COMP_W-1:COMP_W]);
    assign db = abs_diff(qb_reg, rd_data_reg[COMP_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= addr_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        sq_r_reg <= SQ_W'(dr) * SQ_W'(dr);
        sq_g_reg <= SQ_W'(dg) * SQ_W'(dg);
        sq_b_reg <= SQ_W'(db) * SQ_W'(db);
        t_r_reg  <= TERM_W'(sq_r_reg) * TERM_W'(cfg.red_weight);
        t_g_reg  <= TERM_W'(sq_g_reg) * TERM_W'(cfg.green_weight);
        t_b_reg  <= TERM_W'(sq_b_reg) * TERM_W'(cfg.blue_weight);
        dist_reg <= DIST_W'(t_r_reg) + DIST_W'(t_g_reg) + DIST_W'(t_b_reg);
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_out_reg;
    assign best_index    = best_index_reg;
    assign best_distance = best_distance_reg;
    assign exact_match   = exact_match_reg;

endmodule

>>> hw/rtl/nearest_palette_color_search.sv
// Top level of the nearest palette colour search: configuration registers,
// front end queue and back end scan. Depends on npcs_pkg, npcs_front, npcs_back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   input    | in_valid / in_stall       | func, entry_index, red, green, blue
//   output   | out_valid / out_stall     | found, best_index, best_distance, exact_match
//   config   | cfg_write                 | cfg_index, cfg_data
//
// A palette write is done in the back end as it is taken from the queue. A query
// with a palette present makes one memory read per entry through a five-stage
// distance pipeline; a query with no palette skips the scan and goes to its result.
// Reset clears control state and loads the default weights; palette entries
// stay undefined until written. The four-word queue keeps taking input, until it
// is full, while the back end scans or a result waits under out_stall.
`timescale 1ns / 1ps

module nearest_palette_color_search
    import npcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [7:0]            entry_index,
    input  logic [COMP_W-1:0]     red,
    input  logic [COMP_W-1:0]     green,
    input  logic [COMP_W-1:0]     blue,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  found,
    output logic [7:0]            best_index,
    output logic [DIST_W-1:0]     best_distance,
    output logic                  exact_match,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    logic       q_valid;
    logic       q_pop;
    work_item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.palette_present <= 1'b0;
            cfg_reg.red_weight      <= RED_WEIGHT_RST;
            cfg_reg.green_weight    <= GREEN_WEIGHT_RST;
            cfg_reg.blue_weight     <= BLUE_WEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PALETTE_PRESENT: cfg_reg.palette_present <= cfg_data[0];
                CFG_RED_WEIGHT:      cfg_reg.red_weight      <= cfg_data;
                CFG_GREEN_WEIGHT:    cfg_reg.green_weight    <= cfg_data;
                CFG_BLUE_WEIGHT:     cfg_reg.blue_weight     <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    npcs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .entry_index (entry_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item)
    );

    npcs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .best_index    (best_index),
        .best_distance (best_distance),
        .exact_match   (exact_match)
    );

endmodule

>>> tb/sv/nearest_palette_color_search_tb.sv
// Self-checking testbench for nearest_palette_color_search: directed and random
// palette writes and colour queries against an in-bench nearest-entry predictor.
// Depends on npcs_pkg and the nearest_palette_color_search RTL only.
`timescale 1ns / 1ps

module nearest_palette_color_search_tb;

    import npcs_pkg::*;

    localparam int SETTLE_CYCLES    = PALETTE_ENTRIES + 40;
    localparam int LONG_HOLD_CYCLES = 1200;
    localparam int WATCHDOG_LIMIT   = 20000;

    typedef struct packed {
        logic              found;
        logic [7:0]        index;
        logic [DIST_W-1:0] distance;
        logic              exact;
    } match_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  func;
    logic [7:0]            entry_index;
    logic [COMP_W-1:0]     red;
    logic [COMP_W-1:0]     green;
    logic [COMP_W-1:0]     blue;
    logic                  out_valid;
    logic                  out_stall;
    logic                  found;
    logic [7:0]            best_index;
    logic [DIST_W-1:0]     best_distance;
    logic                  exact_match;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    logic [23:0]         palette_model [PALETTE_ENTRIES];
    logic                present_model = 1'b0;
    logic [WEIGHT_W-1:0] red_w_model   = RED_WEIGHT_RST;
    logic [WEIGHT_W-1:0] green_w_model = GREEN_WEIGHT_RST;
    logic [WEIGHT_W-1:0] blue_w_model  = BLUE_WEIGHT_RST;

    match_t pending_matches [$];
    int     mismatch_count    = 0;
    bit     no_idle           = 1'b0;
    bit     long_hold_pending = 1'b0;

    nearest_palette_color_search i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .best_index    (best_index),
        .best_distance (best_distance),
        .exact_match   (exact_match),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic match_t nearest_entry(input logic [7:0] r, g, b);
        match_t      m;
        logic [7:0]  dr, dg, db;
        logic [23:0] e;
        logic [33:0] dsum;
        m = '0;
        if (!present_model)
            return m;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            e    = palette_model[i];
            dr   = (r >= e[23:16]) ? r - e[23:16] : e[23:16] - r;
            dg   = (g >= e[15:8])  ? g - e[15:8]  : e[15:8] - g;
            db   = (b >= e[7:0])   ? b - e[7:0]   : e[7:0] - b;
            dsum = 34'(dr) * 34'(dr) * 34'(red_w_model)
                 + 34'(dg) * 34'(dg) * 34'(green_w_model)
                 + 34'(db) * 34'(db) * 34'(blue_w_model);
            if (i == 0 || dsum < 34'(m.distance))
            begin
                m.index    = 8'(i);
                m.distance = DIST_W'(dsum);
            end
            if (dsum == '0)
                break;
        end
        m.found = 1'b1;
        m.exact = (m.distance == '0);
        return m;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // One word per call; the predictor advances when the word is taken.
    task automatic send_word(input op_t op, input logic [7:0] idx, input logic [7:0] r, g, b);
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op;
        entry_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_WRITE)
            palette_model[idx] = {r, g, b};
        else
            pending_matches.push_back(nearest_entry(r, g, b));
    endtask

    task automatic send_random_word(input int write_pct);
        logic [7:0]  idx, r, g, b;
        logic [23:0] e;
        int          pick;
        idx = 8'($urandom);
        r   = 8'($urandom);
        g   = 8'($urandom);
        b   = 8'($urandom);
        if ($urandom_range(0, 99) < write_pct)
            send_word(OP_WRITE, idx, r, g, b);
        else
        begin
            e    = palette_model[$urandom_range(0, PALETTE_ENTRIES - 1)];
            pick = $urandom_range(0, 2);
            if (pick == 1)
                {r, g, b} = e;
            else if (pick == 2)
            begin
                // near miss around an existing entry
                r = e[23:16] ^ 8'($urandom_range(0, 3));
                g = e[15:8]  ^ 8'($urandom_range(0, 3));
                b = e[7:0]   ^ 8'($urandom_range(0, 3));
            end
            send_word(OP_QUERY, idx, r, g, b);
        end
    endtask

    task automatic load_palette(input bit all_black);
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            if (all_black)
                send_word(OP_WRITE, 8'(i), 8'd0, 8'd0, 8'd0);
            else
                send_word(OP_WRITE, 8'(i), 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // Drop valid, wait out every result and any trailing palette writes.
    task automatic let_block_settle();
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(input bit with_weights, input logic present,
                                     input logic [WEIGHT_W-1:0] rw, gw, bw);
        cfg_reg_t            regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        int                  n;
        regs = '{CFG_PALETTE_PRESENT, CFG_RED_WEIGHT, CFG_GREEN_WEIGHT, CFG_BLUE_WEIGHT};
        vals = '{CFG_DATA_W'(present), rw, gw, bw};
        n    = with_weights ? 4 : 1;
        cfg_write <= 1'b1;
        for (int k = 0; k < n; k++)
        begin
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        present_model = present;
        if (with_weights)
        begin
            red_w_model   = rw;
            green_w_model = gw;
            blue_w_model  = bw;
        end
    endtask

    task automatic test_no_palette();
        send_word(OP_QUERY, 8'd0,   8'd0,   8'd0,   8'd0);
        send_word(OP_QUERY, 8'd255, 8'd255, 8'd255, 8'd255);
        send_word(OP_WRITE, 8'd3,   8'd1,   8'd2,   8'd3);
        send_word(OP_QUERY, 8'd17,  8'd1,   8'd2,   8'd3);
        send_word(OP_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        let_block_settle();
    endtask

    // Reset weights still in force; only the presence flag is written.
    task automatic test_default_weights();
        load_palette(1'b0);
        // duplicate colour so the lower index must win the tie
        send_word(OP_WRITE, 8'd200, palette_model[10][23:16], palette_model[10][15:8],
                  palette_model[10][7:0]);
        let_block_settle();
        program_registers(1'b0, 1'b1, '0, '0, '0);
        send_word(OP_QUERY, 8'd0, palette_model[200][23:16], palette_model[200][15:8],
                  palette_model[200][7:0]);
        send_word(OP_QUERY, 8'd0, palette_model[0][23:16], palette_model[0][15:8],
                  palette_model[0][7:0]);
        send_word(OP_QUERY, 8'd255, palette_model[255][23:16], palette_model[255][15:8],
                  palette_model[255][7:0]);
        send_word(OP_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(OP_QUERY, 8'd0, 8'd255, 8'd255, 8'd255);
        send_word(OP_QUERY, 8'd0, 8'($urandom), 8'($urandom), 8'($urandom));
        let_block_settle();
    endtask

    task automatic test_weight_extremes();
        program_registers(1'b1, 1'b1, '0, '0, '0);
        send_word(OP_QUERY, 8'd0, 8'd255, 8'd0, 8'd128);
        let_block_settle();
        program_registers(1'b1, 1'b1, '1, '1, '1);
        load_palette(1'b1);
        send_word(OP_QUERY, 8'd0, 8'd255, 8'd255, 8'd255);
        send_word(OP_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(OP_WRITE, 8'd255, 8'd255, 8'd255, 8'd255);
        send_word(OP_QUERY, 8'd0, 8'd255, 8'd255, 8'd255);
        send_word(OP_QUERY, 8'd0, 8'd128, 8'd128, 8'd128);
        let_block_settle();
        program_registers(1'b1, 1'b1, '1, '0, '0);
        send_word(OP_QUERY, 8'd0, 8'd0, 8'd255, 8'd255);
        send_word(OP_QUERY, 8'd0, 8'd200, 8'd10, 8'd90);
        let_block_settle();
    endtask

    task automatic test_random_phases();
        load_palette(1'b0);
        for (int p = 0; p < 6; p++)
        begin
            let_block_settle();
            case (p)
                1:       program_registers(1'b1, 1'b1, '1, '0, 16'd1);
                2:       program_registers(1'b1, 1'b0, 16'($urandom), 16'($urandom),
                                           16'($urandom));
                3:       program_registers(1'b1, 1'b1, 16'd1, 16'd1, 16'd1);
                default: program_registers(1'b1, 1'b1, 16'($urandom), 16'($urandom),
                                           16'($urandom));
            endcase
            repeat (120) send_random_word(35);
        end
        let_block_settle();
    endtask

    // Hold the output off while queries keep coming, so the input stalls.
    task automatic test_backpressure();
        long_hold_pending = 1'b1;
        repeat (12) send_random_word(0);
        let_block_settle();
    endtask

    task automatic test_tail_no_idle();
        no_idle = 1'b1;
        program_registers(1'b1, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
        repeat (60) send_random_word(35);
    endtask

    initial
    begin : stimulus
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= OP_WRITE;
        entry_index <= '0;
        red         <= '0;
        green       <= '0;
        blue        <= '0;
        cfg_write   <= 1'b0;
        cfg_index   <= CFG_PALETTE_PRESENT;
        cfg_data    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_palette();
        test_default_weights();
        test_weight_extremes();
        test_random_phases();
        test_backpressure();
        test_tail_no_idle();

        let_block_settle();
        if (mismatch_count == 0)
            $display("nearest_palette_color_search_tb OK");
        else
            $display("nearest_palette_color_search_tb NOT OK");
        $finish;
    end

    initial
    begin : result_sink
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 13)) @(posedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : result_checker
        match_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_matches.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    want = pending_matches.pop_front();
                    if (found !== want.found)
                        report_mismatch($sformatf("found got %0b want %0b", found, want.found));
                    if (best_index !== want.index)
                        report_mismatch($sformatf("best_index got %0d want %0d",
                                                  best_index, want.index));
                    if (best_distance !== want.distance)
                        report_mismatch($sformatf("best_distance got %0d want %0d",
                                                  best_distance, want.distance));
                    if (exact_match !== want.exact)
                        report_mismatch($sformatf("exact_match got %0b want %0b",
                                                  exact_match, want.exact));
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("nearest_palette_color_search_tb NOT OK");
        $finish;
    end

endmodule
